// File: rtl/core/rfe_pkg.sv
package rfe_pkg;

	// Fixed point format of every value: signed, 32 bits, 16 of them fraction.
	localparam int DW = 32;
	localparam int FB = 16;
	localparam int NUM_KNOTS = 7;

	// Item operations.
	localparam logic OP_EVAL  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Evaluation modes as held in the mode register.
	localparam logic [2:0] MODE_PASS   = 3'd0;
	localparam logic [2:0] MODE_UNIT   = 3'd1;
	localparam logic [2:0] MODE_LINEAR = 3'd2;
	localparam logic [2:0] MODE_PARAB  = 3'd3;
	localparam logic [2:0] MODE_KNOTS  = 3'd4;

	// Work kinds handed from the front to the back.
	localparam logic [2:0] KIND_PASS   = 3'd0;
	localparam logic [2:0] KIND_UNIT   = 3'd1;
	localparam logic [2:0] KIND_LINEAR = 3'd2;
	localparam logic [2:0] KIND_PARAB  = 3'd3;
	localparam logic [2:0] KIND_KNOTS  = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_ZW  = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_EVAL_MODE   = 3'd0;
	localparam logic [2:0] REG_GATE_ENABLE = 3'd1;
	localparam logic [2:0] REG_COEF_A      = 3'd2;
	localparam logic [2:0] REG_COEF_B      = 3'd3;
	localparam logic [2:0] REG_COEF_C      = 3'd4;

	localparam logic signed [31:0] UNIT_VAL = 32'sd65536;

	typedef struct packed {
		logic [2:0]        eval_mode;
		logic              gate_enable;
		logic signed [31:0] coef_a;
		logic signed [31:0] coef_b;
		logic signed [31:0] coef_c;
	} rfe_cfg_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [32:0] d;
		logic signed [31:0] x1;
		logic signed [31:0] y1;
		logic signed [31:0] x2;
		logic signed [31:0] y2;
	} rfe_entry_t;

endpackage

// File: rtl/core/rfe_front.sv
module rfe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  rfe_pkg::rfe_cfg_t   cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [2:0]          knot_index,
	input  logic signed [31:0]  knot_x,
	input  logic signed [31:0]  knot_y,
	input  logic signed [31:0]  sample_x,
	input  logic signed [31:0]  center,
	input  logic                in_region,
	input  logic                q_full,
	output logic                q_push,
	output rfe_pkg::rfe_entry_t q_data
);

	logic               valid_s1;
	logic               op_s1;
	logic [2:0]         idx_s1;
	logic signed [31:0] kx_s1;
	logic signed [31:0] ky_s1;
	logic signed [32:0] d_s1;
	logic               region_s1;

	logic signed [31:0] kx_q [0:rfe_pkg::NUM_KNOTS-1];
	logic signed [31:0] ky_q [0:rfe_pkg::NUM_KNOTS-1];

	logic                          go;
	logic                          accept;
	logic [rfe_pkg::NUM_KNOTS-1:0] ge;
	logic [2:0]                    seg;
	logic [2:0]                    seg_nx;
	logic [2:0]                    kind;

	assign go       = (op_s1 == rfe_pkg::OP_WRITE) || !q_full;
	assign in_stall = valid_s1 && !go;
	assign accept   = in_valid && !in_stall;
	assign q_push   = valid_s1 && (op_s1 == rfe_pkg::OP_EVAL) && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op;
			idx_s1    <= knot_index;
			kx_s1     <= knot_x;
			ky_s1     <= knot_y;
			d_s1      <= $signed({sample_x[31], sample_x}) - $signed({center[31], center});
			region_s1 <= in_region;
		end
	end

	// Knot writes land as the item leaves this stage, so an evaluation behind
	// it always sees the new knot.
	always_ff @(posedge clk) begin
		if (valid_s1 && op_s1 == rfe_pkg::OP_WRITE &&
		    idx_s1 < 3'(rfe_pkg::NUM_KNOTS)) begin
			kx_q[idx_s1] <= kx_s1;
			ky_q[idx_s1] <= ky_s1;
		end
	end

	always_comb begin
		for (int k = 0; k < rfe_pkg::NUM_KNOTS; k++) begin
			ge[k] = d_s1 >= $signed({kx_q[k][31], kx_q[k]});
		end
	end

	// Inner segments are tried first, then outward, then extrapolation.
	always_comb begin
		priority if (ge[2] && !ge[3]) begin
			seg = 3'd2;
		end else if (ge[3] && !ge[4]) begin
			seg = 3'd3;
		end else if (ge[1] && !ge[2]) begin
			seg = 3'd1;
		end else if (ge[4] && !ge[5]) begin
			seg = 3'd4;
		end else if (ge[0] && !ge[1]) begin
			seg = 3'd0;
		end else if (ge[5] && !ge[6]) begin
			seg = 3'd5;
		end else if (!ge[0]) begin
			seg = 3'd0;
		end else begin
			seg = 3'd5;
		end
	end

	assign seg_nx = seg + 3'd1;

	always_comb begin
		unique case (cfg.eval_mode)
			rfe_pkg::MODE_UNIT:   kind = rfe_pkg::KIND_UNIT;
			rfe_pkg::MODE_LINEAR: kind = rfe_pkg::KIND_LINEAR;
			rfe_pkg::MODE_PARAB:  kind = rfe_pkg::KIND_PARAB;
			rfe_pkg::MODE_KNOTS:  kind = rfe_pkg::KIND_KNOTS;
			default:              kind = rfe_pkg::KIND_PASS;
		endcase
		if (cfg.gate_enable && !region_s1) begin
			kind = rfe_pkg::KIND_PASS;
		end
	end

	always_comb begin
		q_data.kind = kind;
		q_data.d    = d_s1;
		q_data.x1   = kx_q[seg];
		q_data.y1   = ky_q[seg];
		q_data.x2   = kx_q[seg_nx];
		q_data.y2   = ky_q[seg_nx];
	end

endmodule

// File: rtl/core/rfe_queue.sv
module rfe_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rfe_pkg::rfe_entry_t wr_data,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output rfe_pkg::rfe_entry_t rd_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	rfe_pkg::rfe_entry_t mem_q [0:DEPTH-1];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = count_q == CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/rfe_back.sv
module rfe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rfe_pkg::rfe_cfg_t   cfg,
	input  logic                q_valid,
	input  rfe_pkg::rfe_entry_t q_data,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  result_value,
	output logic [1:0]          status
);

	localparam int QW = 66;
	localparam logic [63:0] LIM = 64'h2000_0000_0000_0000;

	typedef struct packed {
		logic               v;
		logic               use_div;
		logic               neg;
		logic [32:0]        dv;
		logic [33:0]        rem;
		logic [QW-1:0]      dq;
		logic signed [31:0] y1;
		logic signed [31:0] fv;
		logic [1:0]         fs;
	} dstg_t;

	function automatic logic [32:0] abs33(input logic signed [32:0] v);
		abs33 = v[32] ? 33'(-v) : 33'(v);
	endfunction

	function automatic logic [32:0] abs34(input logic signed [33:0] v);
		logic [33:0] m;
		m = v[33] ? 34'(-v) : 34'(v);
		abs34 = m[32:0];
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		abs32 = v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		priority if (v > 64'sd2147483647) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	function automatic logic ovf32(input logic signed [63:0] v);
		ovf32 = (v > 64'sd2147483647) || (v < -64'sd2147483648);
	endfunction

	logic adv;

	// Stage 1: differences.
	logic               v_s1;
	logic [2:0]         kind_s1;
	logic signed [32:0] d_s1;
	logic signed [32:0] dx_s1;
	logic signed [32:0] dy_s1;
	logic signed [33:0] t_s1;
	logic signed [31:0] y1_s1;

	// Stage 2: magnitude products.
	logic               v_s2;
	logic [2:0]         kind_s2;
	logic signed [32:0] d_s2;
	logic [65:0]        pa_s2;
	logic [64:0]        pb_s2;
	logic               negb_s2;
	logic               negq_s2;
	logic [32:0]        dv_s2;
	logic               zw_s2;
	logic signed [31:0] y1_s2;

	// Stage 3: quadratic partial products.
	logic               v_s3;
	logic [2:0]         kind_s3;
	logic signed [32:0] d_s3;
	logic [65:0]        pa_s3;
	logic [56:0]        plo_s3;
	logic [56:0]        phi_s3;
	logic signed [63:0] bd_s3;
	logic               negq_s3;
	logic [32:0]        dv_s3;
	logic               zw_s3;
	logic signed [31:0] y1_s3;

	// Stage 4: scaled and clamped quadratic term.
	logic               v_s4;
	logic [2:0]         kind_s4;
	logic signed [32:0] d_s4;
	logic [65:0]        pa_s4;
	logic signed [63:0] bd_s4;
	logic signed [63:0] csq_s4;
	logic               negq_s4;
	logic [32:0]        dv_s4;
	logic               zw_s4;
	logic signed [31:0] y1_s4;

	dstg_t dstg_s [0:QW];

	logic               out_valid_q;
	logic signed [31:0] result_q;
	logic [1:0]         status_q;

	assign adv   = !out_valid_q || !out_stall;
	assign q_pop = adv && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= q_data.kind;
			d_s1    <= q_data.d;
			dx_s1   <= $signed({q_data.x2[31], q_data.x2}) - $signed({q_data.x1[31], q_data.x1});
			dy_s1   <= $signed({q_data.y2[31], q_data.y2}) - $signed({q_data.y1[31], q_data.y1});
			t_s1    <= $signed({q_data.d[32], q_data.d}) -
			           $signed({{2{q_data.x1[31]}}, q_data.x1});
			y1_s1   <= q_data.y1;
		end
	end

	logic [32:0] ma;
	logic [32:0] mb;
	logic [32:0] md;

	always_comb begin
		md = abs33(d_s1);
		if (kind_s1 == rfe_pkg::KIND_KNOTS) begin
			ma = abs33(dy_s1);
			mb = abs34(t_s1);
		end else begin
			ma = md;
			mb = md;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= kind_s1;
			d_s2    <= d_s1;
			pa_s2   <= 66'(ma) * 66'(mb);
			pb_s2   <= 65'(abs32(cfg.coef_b)) * 65'(md);
			negb_s2 <= cfg.coef_b[31] ^ d_s1[32];
			negq_s2 <= dy_s1[32] ^ t_s1[33] ^ dx_s1[32];
			dv_s2   <= abs33(dx_s1);
			zw_s2   <= dx_s1 == '0;
			y1_s2   <= y1_s1;
		end
	end

	logic [49:0] sq;
	logic [31:0] mc;
	logic [63:0] bd_mag;

	assign sq     = pa_s2[65:16];
	assign mc     = abs32(cfg.coef_c);
	assign bd_mag = 64'(pb_s2[64:16]);

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s3 <= kind_s2;
			d_s3    <= d_s2;
			pa_s3   <= pa_s2;
			plo_s3  <= 57'(mc) * 57'(sq[24:0]);
			phi_s3  <= 57'(mc) * 57'(sq[49:25]);
			bd_s3   <= negb_s2 ? -$signed(bd_mag) : $signed(bd_mag);
			negq_s3 <= negq_s2;
			dv_s3   <= dv_s2;
			zw_s3   <= zw_s2;
			y1_s3   <= y1_s2;
		end
	end

	logic [81:0] csum;
	logic [65:0] cab;
	logic [63:0] ccl;

	always_comb begin
		csum = {phi_s3, 25'b0} + 82'(plo_s3);
		cab  = csum[81:16];
		ccl  = (cab > 66'(LIM)) ? LIM : cab[63:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s4 <= kind_s3;
			d_s4    <= d_s3;
			pa_s4   <= pa_s3;
			bd_s4   <= bd_s3;
			if (kind_s3 != rfe_pkg::KIND_PARAB) begin
				csq_s4 <= '0;
			end else begin
				csq_s4 <= cfg.coef_c[31] ? -$signed(ccl) : $signed(ccl);
			end
			negq_s4 <= negq_s3;
			dv_s4   <= dv_s3;
			zw_s4   <= zw_s3;
			y1_s4   <= y1_s3;
		end
	end

	// Stage 5 settles every result that needs no division and loads the
	// divider with the product that the knot segment divides.
	logic signed [63:0] dsx;
	logic signed [63:0] psum;
	dstg_t              head;

	always_comb begin
		dsx  = 64'(d_s4);
		psum = 64'(cfg.coef_a) + bd_s4 + csq_s4;
		head         = '0;
		head.v       = v_s4;
		head.neg     = negq_s4;
		head.dv      = dv_s4;
		head.rem     = '0;
		head.dq      = pa_s4;
		head.y1      = y1_s4;
		head.use_div = 1'b0;
		unique case (kind_s4)
			rfe_pkg::KIND_UNIT: begin
				head.fv = rfe_pkg::UNIT_VAL;
				head.fs = rfe_pkg::ST_OK;
			end
			rfe_pkg::KIND_LINEAR, rfe_pkg::KIND_PARAB: begin
				head.fv = sat32(psum);
				head.fs = ovf32(psum) ? rfe_pkg::ST_SAT : rfe_pkg::ST_OK;
			end
			rfe_pkg::KIND_KNOTS: begin
				head.fv      = y1_s4;
				head.fs      = rfe_pkg::ST_ZW;
				head.use_div = !zw_s4;
			end
			default: begin
				head.fv = sat32(dsx);
				head.fs = ovf32(dsx) ? rfe_pkg::ST_SAT : rfe_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dstg_s[0].v <= 1'b0;
		end else if (adv) begin
			dstg_s[0] <= head;
		end
	end

	// Restoring division, one quotient bit per stage.
	for (genvar g = 0; g < QW; g++) begin : g_div
		dstg_t       nxt;
		logic [33:0] r;
		logic        ge;

		always_comb begin
			r       = {dstg_s[g].rem[32:0], dstg_s[g].dq[QW-1]};
			ge      = r >= {1'b0, dstg_s[g].dv};
			nxt     = dstg_s[g];
			nxt.rem = ge ? r - {1'b0, dstg_s[g].dv} : r;
			nxt.dq  = {dstg_s[g].dq[QW-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dstg_s[g+1].v <= 1'b0;
			end else if (adv) begin
				dstg_s[g+1] <= nxt;
			end
		end
	end

	logic [63:0]        qcl;
	logic signed [63:0] qs;
	logic signed [63:0] isum;

	always_comb begin
		qcl  = (dstg_s[QW].dq > QW'(LIM)) ? LIM : dstg_s[QW].dq[63:0];
		qs   = dstg_s[QW].neg ? -$signed(qcl) : $signed(qcl);
		isum = 64'(dstg_s[QW].y1) + qs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dstg_s[QW].v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (dstg_s[QW].use_div) begin
				result_q <= sat32(isum);
				status_q <= ovf32(isum) ? rfe_pkg::ST_SAT : rfe_pkg::ST_OK;
			end else begin
				result_q <= dstg_s[QW].fv;
				status_q <= dstg_s[QW].fs;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign status       = status_q;

endmodule

// File: rtl/core/response_function_evaluator.sv
// Response function evaluator: evaluates a chosen function of d = sample_x - center.
// Input channel (in_valid/in_stall): an item with op = 0 evaluates at sample_x
// minus center and gives exactly one result; op = 1 loads knot knot_index with
// knot_x/knot_y and gives none. Results leave on the output channel
// (out_valid/out_stall) as result_value and status, in the order of the items.
// Configuration (mode, gate, coefficients) is written over the APB port at byte
// addresses 0, 4, 8, 12 and 16; the user must do so only while no item is in
// flight, as the block does not enforce it. Throughput: one item per cycle
// while the input is not stalled. Every evaluation takes the same path length,
// through the 66-stage restoring divider of the knot path, so results stay in order.
// The front stage and the back pipeline are parted by a small queue, so the
// input keeps flowing until that queue fills while the receiver stalls.
// While out_stall is high and a result is valid, the result holds and the back
// pipeline freezes. Reset clears the configuration registers to zero and empties
// the queue and the pipeline; the knots are undefined until written.
module response_function_evaluator #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [2:0]         knot_index,
	input  logic signed [31:0] knot_x,
	input  logic signed [31:0] knot_y,
	input  logic signed [31:0] sample_x,
	input  logic signed [31:0] center,
	input  logic               in_region,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_value,
	output logic [1:0]         status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [2:0]         eval_mode_q;
	logic               gate_enable_q;
	logic signed [31:0] coef_a_q;
	logic signed [31:0] coef_b_q;
	logic signed [31:0] coef_c_q;

	logic                reg_wr;
	logic [2:0]          reg_idx;
	rfe_pkg::rfe_cfg_t   cfg;
	logic                q_push;
	logic                q_pop;
	logic                q_full;
	logic                q_valid;
	rfe_pkg::rfe_entry_t q_wdata;
	rfe_pkg::rfe_entry_t q_rdata;

	// The register index is the word address; the byte offset is ignored.
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_mode_q   <= rfe_pkg::MODE_PASS;
			gate_enable_q <= 1'b0;
			coef_a_q      <= '0;
			coef_b_q      <= '0;
			coef_c_q      <= '0;
		end else if (reg_wr) begin
			unique case (reg_idx)
				rfe_pkg::REG_EVAL_MODE:   eval_mode_q   <= pwdata[2:0];
				rfe_pkg::REG_GATE_ENABLE: gate_enable_q <= pwdata[0];
				rfe_pkg::REG_COEF_A:      coef_a_q      <= pwdata;
				rfe_pkg::REG_COEF_B:      coef_b_q      <= pwdata;
				rfe_pkg::REG_COEF_C:      coef_c_q      <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			rfe_pkg::REG_EVAL_MODE:   prdata = {29'b0, eval_mode_q};
			rfe_pkg::REG_GATE_ENABLE: prdata = {31'b0, gate_enable_q};
			rfe_pkg::REG_COEF_A:      prdata = coef_a_q;
			rfe_pkg::REG_COEF_B:      prdata = coef_b_q;
			rfe_pkg::REG_COEF_C:      prdata = coef_c_q;
			default:                  prdata = '0;
		endcase
	end

	always_comb begin
		cfg.eval_mode   = eval_mode_q;
		cfg.gate_enable = gate_enable_q;
		cfg.coef_a      = coef_a_q;
		cfg.coef_b      = coef_b_q;
		cfg.coef_c      = coef_c_q;
	end

	// The front takes items, applies knot writes and picks the work kind and
	// the knot segment for each evaluation.
	rfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.knot_index (knot_index),
		.knot_x     (knot_x),
		.knot_y     (knot_y),
		.sample_x   (sample_x),
		.center     (center),
		.in_region  (in_region),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	rfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_data   (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.rd_data   (q_rdata)
	);

	// The back pipeline does the arithmetic and holds the output register.
	rfe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_valid      (q_valid),
		.q_data       (q_rdata),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.status       (status)
	);

`ifndef ASSERT_OFF
	// A write to the mode register takes effect at the next edge.
	a_mode_write: assert property (@(posedge clk) disable iff (!arst_n)
		reg_wr && reg_idx == rfe_pkg::REG_EVAL_MODE |=> eval_mode_q == $past(pwdata[2:0]))
		else $error("mode register did not take the written value");

	// A zero-width segment can only be reported in seven-knot mode.
	a_zw_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == rfe_pkg::ST_ZW |-> eval_mode_q == rfe_pkg::MODE_KNOTS)
		else $error("zero-width status outside seven-knot mode");

	// Ungated unit mode always answers exactly 1.0 without saturation.
	a_unit_val: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && eval_mode_q == rfe_pkg::MODE_UNIT && !gate_enable_q
		|-> result_value == rfe_pkg::UNIT_VAL && status == rfe_pkg::ST_OK)
		else $error("unit mode result is not 1.0");
`endif

endmodule

// File: bench/tb_top.sv
module tb_top;

	// Clock and reset. Reset is held at the start and then released for good.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	// Item channel into the block and result channel out of it.
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               op = rfe_pkg::OP_EVAL;
	logic [2:0]         knot_index = '0;
	logic signed [31:0] knot_x = '0;
	logic signed [31:0] knot_y = '0;
	logic signed [31:0] sample_x = '0;
	logic signed [31:0] center = '0;
	logic               in_region = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] result_value;
	logic [1:0]         status;

	// Register port.
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	response_function_evaluator i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .knot_index(knot_index), .knot_x(knot_x), .knot_y(knot_y),
		.sample_x(sample_x), .center(center), .in_region(in_region),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_value(result_value), .status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// One expected result: the saturated value and its status code.
	typedef struct {
		logic signed [31:0] value;
		logic [1:0]         code;
	} response_t;

	response_t pending_responses[$];

	// Our own copy of the configuration and the knot tables.
	logic [2:0]  mode_shadow = rfe_pkg::MODE_PASS;
	logic        gate_shadow = 1'b0;
	longint      coef_a_shadow = 0;
	longint      coef_b_shadow = 0;
	longint      coef_c_shadow = 0;
	longint      knot_x_shadow[rfe_pkg::NUM_KNOTS];
	longint      knot_y_shadow[rfe_pkg::NUM_KNOTS];

	int  mismatches = 0;
	int  cycle_count = 0;
	bit  idle_enable = 1'b1;
	bit  hold_request = 1'b0;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES = 600;
	localparam logic [127:0] WORK_LIMIT = 128'd1 << 61;

	// Every intermediate product or quotient is limited to 2^61 in magnitude,
	// keeping its sign, before it joins the final sum.
	function automatic logic signed [127:0] limit_work(bit neg, logic [127:0] m);
		logic [127:0] lim;
		lim = (m > WORK_LIMIT) ? WORK_LIMIT : m;
		return neg ? -$signed(lim) : $signed(lim);
	endfunction

	function automatic logic [127:0] magnitude(longint v);
		logic signed [127:0] w;
		w = v;
		return (w < 0) ? -w : w;
	endfunction

	// Fixed point product, scaled back by the fraction bits, truncated toward zero.
	function automatic logic signed [127:0] scaled_product(longint a, longint b);
		logic [127:0] p;
		p = (magnitude(a) * magnitude(b)) >> rfe_pkg::FB;
		return limit_work((a < 0) != (b < 0), p);
	endfunction

	// a * b / den with the quotient truncated toward zero; den is never zero.
	function automatic logic signed [127:0] scaled_ratio(longint a, longint b, longint den);
		logic [127:0] q;
		q = (magnitude(a) * magnitude(b)) / magnitude(den);
		return limit_work(((a < 0) != (b < 0)) != (den < 0), q);
	endfunction

	function automatic logic signed [31:0] clip32(logic signed [127:0] v,
			inout logic [1:0] code);
		if (v > 128'sd2147483647) begin
			code = rfe_pkg::ST_SAT;
			return 32'sh7fffffff;
		end
		if (v < -128'sd2147483648) begin
			code = rfe_pkg::ST_SAT;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// The seven-knot curve. The middle segments are tried first, then the outer
	// ones; an argument outside every segment extrapolates along an end segment.
	function automatic response_t knot_curve(longint d);
		int          seg_order[6] = '{2, 3, 1, 4, 0, 5};
		int          seg;
		longint      dx;
		response_t   r;
		seg = -1;
		r.code = rfe_pkg::ST_OK;
		foreach (seg_order[i])
			if (seg < 0 && d >= knot_x_shadow[seg_order[i]] &&
					d < knot_x_shadow[seg_order[i] + 1])
				seg = seg_order[i];
		if (seg < 0)
			seg = (d < knot_x_shadow[0]) ? 0 : 5;
		dx = knot_x_shadow[seg + 1] - knot_x_shadow[seg];
		if (dx == 0) begin
			// A segment of zero width gives its left ordinate and is flagged.
			r.value = 32'(knot_y_shadow[seg]);
			r.code = rfe_pkg::ST_ZW;
		end else begin
			r.value = clip32(knot_y_shadow[seg] + scaled_ratio(
					knot_y_shadow[seg + 1] - knot_y_shadow[seg],
					d - knot_x_shadow[seg], dx), r.code);
		end
		return r;
	endfunction

	function automatic response_t evaluate_response(logic signed [31:0] sx,
			logic signed [31:0] c, logic rgn);
		longint            d;
		logic signed [127:0] sum;
		response_t         r;
		d = longint'(sx) - longint'(c);
		r.code = rfe_pkg::ST_OK;
		// Undefined modes and a gated evaluation outside the region pass d through.
		if (mode_shadow == rfe_pkg::MODE_PASS || mode_shadow > rfe_pkg::MODE_KNOTS ||
				(gate_shadow && !rgn))
			r.value = clip32(d, r.code);
		else if (mode_shadow == rfe_pkg::MODE_UNIT)
			r.value = clip32(rfe_pkg::UNIT_VAL, r.code);
		else if (mode_shadow == rfe_pkg::MODE_LINEAR) begin
			sum = coef_a_shadow + scaled_product(coef_b_shadow, d);
			r.value = clip32(sum, r.code);
		end else if (mode_shadow == rfe_pkg::MODE_PARAB) begin
			sum = coef_a_shadow + scaled_product(coef_b_shadow, d) +
					scaled_product(coef_c_shadow, longint'(scaled_product(d, d)));
			r.value = clip32(sum, r.code);
		end else
			r = knot_curve(d);
		return r;
	endfunction

	// Result checker: every accepted result is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_responses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result value=%0d status=%0d",
							result_value, status);
			end else begin
				response_t exp_r;
				exp_r = pending_responses.pop_front();
				if (result_value !== exp_r.value || status !== exp_r.code) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
								exp_r.value, exp_r.code, result_value, status);
				end
			end
		end
	end

	// Receiver. It stalls in random bursts while idling is enabled and, on
	// request, holds off for a long stretch so that the block backs up.
	initial begin
		forever begin
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (idle_enable && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL response_function_evaluator");
			$finish;
		end
	end

	// Sends one item and waits until the block takes it. The payload stays put
	// while the block stalls; the expectation is recorded at acceptance.
	task automatic send_item(logic item_op, logic [2:0] idx, logic signed [31:0] kx,
			logic signed [31:0] ky, logic signed [31:0] sx, logic signed [31:0] c,
			logic rgn);
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= item_op;
		knot_index <= idx;
		knot_x <= kx;
		knot_y <= ky;
		sample_x <= sx;
		center <= c;
		in_region <= rgn;
		do @(posedge clk); while (in_stall);
		if (item_op == rfe_pkg::OP_WRITE) begin
			if (idx < rfe_pkg::NUM_KNOTS) begin
				knot_x_shadow[idx] = longint'(kx);
				knot_y_shadow[idx] = longint'(ky);
			end
		end else
			pending_responses.push_back(evaluate_response(sx, c, rgn));
	endtask

	task automatic evaluate_at(logic signed [31:0] sx, logic signed [31:0] c, logic rgn);
		send_item(rfe_pkg::OP_EVAL, 3'($urandom), $urandom, $urandom, sx, c, rgn);
	endtask

	// Waits until every expected result has come, then lets the pipeline settle
	// so that no knot write or evaluation is still on its way.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write over the configuration port: setup, access, then idle
	// before the next transfer.
	task automatic write_register(logic [2:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			rfe_pkg::REG_EVAL_MODE:   mode_shadow = value[2:0];
			rfe_pkg::REG_GATE_ENABLE: gate_shadow = value[0];
			rfe_pkg::REG_COEF_A:      coef_a_shadow = longint'($signed(value));
			rfe_pkg::REG_COEF_B:      coef_b_shadow = longint'($signed(value));
			rfe_pkg::REG_COEF_C:      coef_c_shadow = longint'($signed(value));
			default: ;
		endcase
	endtask

	task automatic set_configuration(logic [2:0] mode, logic gate, logic [31:0] a,
			logic [31:0] b, logic [31:0] c);
		wait_drained();
		write_register(rfe_pkg::REG_EVAL_MODE, {29'd0, mode});
		write_register(rfe_pkg::REG_GATE_ENABLE, {31'd0, gate});
		write_register(rfe_pkg::REG_COEF_A, a);
		write_register(rfe_pkg::REG_COEF_B, b);
		write_register(rfe_pkg::REG_COEF_C, c);
	endtask

	// Loads seven knots in ascending order, spaced at random around zero.
	task automatic load_sorted_knots(int unsigned max_step);
		logic signed [31:0] x;
		x = -$signed(32'($urandom_range(0, max_step * 3)));
		for (int k = 0; k < rfe_pkg::NUM_KNOTS; k++) begin
			send_item(rfe_pkg::OP_WRITE, k[2:0], x, $urandom, $urandom, $urandom,
					1'($urandom));
			x = x + $signed(32'($urandom_range(1, max_step)));
		end
	endtask

	// A value for a random field: small, full range or an extreme, each about as often.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
			default: return $urandom;
		endcase
	endfunction

	// Extremes of the fields, every mode and each special case.
	task automatic test_directed();
		set_configuration(rfe_pkg::MODE_PASS, 1'b0, 32'd0, 32'd0, 32'd0);
		// Knots at minus three to plus three sigma, unit spacing, y = x squared.
		for (int k = 0; k < rfe_pkg::NUM_KNOTS; k++)
			send_item(rfe_pkg::OP_WRITE, k[2:0], (k - 3) * 65536, (k - 3) * (k - 3) * 65536,
					$urandom, $urandom, 1'($urandom));
		// A write to index seven must be ignored.
		send_item(rfe_pkg::OP_WRITE, 3'd7, 32'sh7fffffff, 32'sh80000000, '0, '0, 1'b0);
		// Pass-through of a difference that overflows either way.
		evaluate_at(32'sh7fffffff, 32'sh80000000, 1'b1);
		evaluate_at(32'sh80000000, 32'sh7fffffff, 1'b0);
		evaluate_at(32'sh0001_8000, 32'sh0000_8000, 1'b1);
		set_configuration(rfe_pkg::MODE_UNIT, 1'b0, 32'd0, 32'd0, 32'd0);
		evaluate_at(32'sh7fffffff, 32'sh0, 1'b0);
		set_configuration(rfe_pkg::MODE_LINEAR, 1'b1, 32'h7fffffff, 32'h7fffffff,
				32'h80000000);
		evaluate_at(32'sh7fffffff, 32'sh80000000, 1'b1);
		// Gating outside the region returns the argument.
		evaluate_at(32'sh0002_0000, 32'sh0, 1'b0);
		set_configuration(rfe_pkg::MODE_PARAB, 1'b0, 32'h80000000, 32'h80000000,
				32'h7fffffff);
		evaluate_at(32'sh80000000, 32'sh7fffffff, 1'b1);
		evaluate_at(32'sh0000_4000, 32'sh0, 1'b0);
		set_configuration(rfe_pkg::MODE_KNOTS, 1'b0, 32'd0, 32'd0, 32'd0);
		evaluate_at(32'sh0000_8000, 32'sh0, 1'b1);
		evaluate_at(-32'sh0005_0000, 32'sh0, 1'b1);
		evaluate_at(32'sh0005_0000, 32'sh0, 1'b1);
		evaluate_at(32'sh7fffffff, 32'sh80000000, 1'b1);
		// Knot three moved onto knot two, then knot four behind them: unsorted.
		send_item(rfe_pkg::OP_WRITE, 3'd3, -32'sh0001_0000, 32'sh0004_0000, '0, '0, 1'b0);
		evaluate_at(-32'sh0001_0000, 32'sh0, 1'b1);
		send_item(rfe_pkg::OP_WRITE, 3'd4, -32'sh0003_0000, 32'sh0001_0000, '0, '0, 1'b0);
		evaluate_at(32'sh0000_2000, 32'sh0, 1'b1);
		// Knot one moved onto knot zero; left of both, the first segment has zero width.
		send_item(rfe_pkg::OP_WRITE, 3'd1, -32'sh0003_0000, 32'sh0002_0000, '0, '0, 1'b0);
		evaluate_at(-32'sh0005_0000, 32'sh0, 1'b1);
		// Undefined modes behave as pass-through.
		set_configuration(3'd7, 1'b0, 32'd0, 32'd0, 32'd0);
		evaluate_at(32'sh0003_0000, 32'sh0001_0000, 1'b0);
		set_configuration(3'd5, 1'b0, 32'd0, 32'd0, 32'd0);
		evaluate_at(32'sh80000000, 32'sh1, 1'b1);
	endtask

	// One random phase under a given configuration. Whatever the mode, the knot table
	// is reloaded in order now and then, with stray single writes as noise.
	task automatic test_random_phase(int n_items);
		logic [2:0] mode;
		logic signed [31:0] c;
		mode = 3'($urandom_range(0, 7));
		set_configuration(mode, 1'($urandom_range(0, 1)),
				($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000),
				($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000),
				($urandom_range(0, 2) == 0) ? 32'h80000000 : $urandom);
		load_sorted_knots(($urandom_range(0, 1) == 0) ? 32'h0002_0000 : 32'h1000_0000);
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 29) == 0)
				load_sorted_knots($urandom_range(1, 32'h0800_0000));
			else if ($urandom_range(0, 9) == 0)
				send_item(rfe_pkg::OP_WRITE, 3'($urandom_range(0, 7)), pick_value(),
						pick_value(), $urandom, $urandom, 1'($urandom));
			else begin
				c = pick_value();
				if ($urandom_range(0, 3) == 0)
					evaluate_at(pick_value(), c, 1'($urandom_range(0, 1)));
				else
					evaluate_at(c + ($signed(32'($urandom_range(0, 32'h0010_0000)))
							- 32'sh0008_0000), c, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// The receiver holds off for a long stretch while items keep coming, so the
	// whole pipeline and the queue fill up and the input has to stall.
	task automatic test_backpressure();
		set_configuration(rfe_pkg::MODE_KNOTS, 1'b0, 32'd0, 32'd0, 32'd0);
		hold_request = 1'b1;
		for (int i = 0; i < 150; i++)
			evaluate_at(pick_value(), pick_value(), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		for (int p = 0; p < 5; p++)
			test_random_phase(90);
		test_backpressure();
		// The sender pauses here until everything has come out.
		wait_drained();
		// The last stretch runs with no idling on either side.
		idle_enable = 1'b0;
		test_random_phase(100);
		wait_drained();
		if (mismatches == 0)
			$display("PASS response_function_evaluator");
		else
			$display("FAIL response_function_evaluator");
		$finish;
	end

endmodule

// File: files.f
rtl/core/rfe_pkg.sv
rtl/core/rfe_front.sv
rtl/core/rfe_queue.sv
rtl/core/rfe_back.sv
rtl/core/response_function_evaluator.sv
bench/tb_top.sv
